[sv/sfr_pkg.sv]
package sfr_pkg;

    localparam logic [7:0]  START_BYTE = 8'hAE;
    localparam logic [7:0]  ESC_BYTE   = 8'hAD;
    localparam logic [7:0]  ESC_AS_ESC = 8'h00;
    localparam logic [7:0]  ESC_AS_SOF = 8'h01;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;

    typedef enum logic [1:0] {
        ST_CRC_GOOD  = 2'd0,
        ST_CRC_BAD   = 2'd1,
        ST_RESTARTED = 2'd2,
        ST_BAD_ESC   = 2'd3
    } frame_status_t;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t  kind;
        logic [7:0]    data_byte;
        frame_status_t frame_status;
        logic [7:0]    frame_length;
    } result_t;

    // reflected CRC-16, one byte, bit at a time (eight narrow steps)
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[sv/stuffed_frame_receiver_crc16.sv]
// Channel  | Dir | tdata (low bit up)                          | tuser
// ---------+-----+---------------------------------------------+---------------------
// s_axis   | in  | [7:0] rx_byte                               | -
// m_axis   | out | [7:0] data_byte, [9:8] frame_status,        | [0] kind
//          |     | [17:10] frame_length, [23:18] zero          | (0 payload, 1 end)
//
// One input beat per cycle, sustained while m_axis takes its results. A beat lands
// in the input register, then the unstuff/CRC/frame logic loads its result, if the
// beat has one, into the result register, which offers it on m_axis (not every beat yields one).
// rst_n (async, active low) puts the receiver in hunt with CRC at 0xFFFF.
// A stalled m_axis holds the result register; the input register then holds
// one more beat and s_axis_tready drops until the waiting result beat is taken.
module stuffed_frame_receiver_crc16
    import sfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                                   // [17:10] frame_length
    output logic                   m_axis_tuser    // [0] kind
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       can_load;
    logic       proc_fire;
    logic       res_valid;
    result_t    res;

    // a held beat is processed when the result register can take its result
    assign proc_fire     = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || proc_fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    sfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (proc_fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sfr_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (proc_fire),
        .res_valid     (res_valid),
        .res           (res),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[sv/sfr_core.sv]
module sfr_core
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output result_t     res
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN    = 3'd1,
        PH_DATA   = 3'd2,
        PH_CRC_LO = 3'd3,
        PH_CRC_HI = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;

    logic        in_frame;
    logic        take;
    logic [7:0]  b_eff;
    logic [7:0]  cnt_inc;
    logic [15:0] crc_upd;

    assign in_frame = (phase_reg == PH_DATA) || (phase_reg == PH_CRC_LO) ||
                      (phase_reg == PH_CRC_HI);
    assign cnt_inc  = cnt_reg + 8'd1;
    assign crc_upd  = crc16_byte(crc_reg, b_eff);

    // unstuffing: decide whether this beat carries a frame byte, then step the frame phases, CRC and result
    always_comb
    begin
        b_eff      = rx_byte;
        take       = 1'b0;
        esc_next   = esc_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        res_valid  = 1'b0;
        res        = '{kind: KIND_FRAME_END, data_byte: 8'h00,
                       frame_status: ST_CRC_GOOD, frame_length: len_reg};

        if (rx_byte == START_BYTE)
        begin
            if (in_frame)
            begin
                res_valid        = 1'b1;
                res.frame_status = ST_RESTARTED;
            end
            phase_next = PH_LEN;
            esc_next   = 1'b0;
        end
        else if (phase_reg == PH_HUNT)
        begin
            take = 1'b0;
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            if (rx_byte == ESC_AS_ESC)
            begin
                b_eff = ESC_BYTE;
                take  = 1'b1;
            end
            else if (rx_byte == ESC_AS_SOF)
            begin
                b_eff = START_BYTE;
                take  = 1'b1;
            end
            else
            begin
                if (in_frame)
                begin
                    res_valid        = 1'b1;
                    res.frame_status = ST_BAD_ESC;
                end
                phase_next = PH_HUNT;
            end
        end
        else if (rx_byte == ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            take = 1'b1;
        end

        if (take)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    len_next   = b_eff;
                    cnt_next   = 8'd0;
                    crc_next   = CRC_INIT;
                    phase_next = (b_eff == 8'd0) ? PH_HUNT : PH_DATA;
                end
                PH_DATA:
                begin
                    crc_next = crc_upd;
                    cnt_next = cnt_inc;
                    if (cnt_inc == len_reg)
                        phase_next = PH_CRC_LO;
                    res_valid = 1'b1;
                    res.kind      = KIND_PAYLOAD;
                    res.data_byte = b_eff;
                end
                PH_CRC_LO:
                begin
                    crc_next   = crc_upd;
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    crc_next   = crc_upd;
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res.frame_status = (crc_upd == 16'h0000) ? ST_CRC_GOOD : ST_CRC_BAD;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            esc_reg   <= 1'b0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

[sv/sfr_out_stage.sv]
module sfr_out_stage
    import sfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   res_valid,
    input  result_t                res,
    output logic                   can_load,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = res_valid;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            res_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {6'd0, res_reg.frame_length, res_reg.frame_status,
                            res_reg.data_byte};

endmodule
